// ===== rtl/core/cfr_pkg.sv =====
// Shared types and constants for the continued fraction ratio unit.
// Used by cfr_div, cfr_dpath, cfr_ctrl and continued_fraction_ratio_unit.
package cfr_pkg;

	localparam int unsigned VALUE_W   = 48;
	localparam int unsigned NUM_W     = 32;
	localparam int unsigned DEN_W     = 16;
	localparam int unsigned FRAC_W    = 32;
	localparam int unsigned DIV_W     = FRAC_W + 1;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
	localparam int unsigned MAX_TERMS = 100;
	localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);
	localparam int unsigned EPS_SCALE = 1000000;
	localparam int unsigned EPS_W     = 20;
	localparam int unsigned FAIL_VALUE = 1000;
	localparam logic [DEN_W-1:0] MAX_DEN_RESET = DEN_W'(1000);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EPS,
		S_EPS_CHK,
		S_DIV,
		S_MUL,
		S_UPD,
		S_FINISH
	} cfr_state_t;

	typedef struct packed {
		logic load;
		logic eps_mul;
		logic div_start;
		logic mul;
		logic update;
		logic out_load;
	} cfr_cmd_t;

	typedef struct packed {
		logic eps_small;
		logic count_full;
		logic div_done;
		logic k_over;
		logic out_free;
	} cfr_sts_t;

endpackage

// ===== rtl/core/cfr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on cfr_pkg for widths.
module cfr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cfr_pkg::DIV_W-1:0]  dividend,
	input  logic [cfr_pkg::FRAC_W-1:0] divisor,
	output logic [cfr_pkg::DIV_W-1:0]  quotient,
	output logic [cfr_pkg::FRAC_W-1:0] remainder,
	output logic                       done
);

	logic [cfr_pkg::FRAC_W-1:0]    rem_q;
	logic [cfr_pkg::DIV_W-1:0]     dq_q;
	logic [cfr_pkg::FRAC_W-1:0]    dvs_q;
	logic [cfr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [cfr_pkg::DIV_W-1:0]     trial;
	logic                          fits;
	logic [cfr_pkg::DIV_W-1:0]     diff;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, dq_q[cfr_pkg::DIV_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// Control: count quotient bits while busy and flag done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cfr_pkg::DIV_CNT_W'(cfr_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[cfr_pkg::FRAC_W-1:0] : trial[cfr_pkg::FRAC_W-1:0];
			dq_q  <= {dq_q[cfr_pkg::DIV_W-2:0], fits};
		end
	end

	assign quotient  = dq_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// ===== rtl/core/cfr_dpath.sv =====
// Datapath: remainder pair, convergent recurrences, limit register, result register.
// Depends on cfr_pkg and cfr_div.
module cfr_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfr_pkg::cfr_cmd_t           cmd,
	output cfr_pkg::cfr_sts_t           sts,
	input  logic [cfr_pkg::VALUE_W-1:0] value_fixed,
	input  logic                        cfg_wr,
	input  logic [cfr_pkg::DEN_W-1:0]   cfg_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [cfr_pkg::NUM_W-1:0]   numerator,
	output logic [cfr_pkg::DEN_W-1:0]   denominator,
	output logic                        failed
);

	localparam int unsigned PROD_W = cfr_pkg::FRAC_W + cfr_pkg::EPS_W;
	localparam int unsigned ASAT_W = cfr_pkg::DEN_W + 1;
	localparam int unsigned KP_W   = ASAT_W + cfr_pkg::DEN_W;
	localparam int unsigned HP_W   = cfr_pkg::DEN_W + cfr_pkg::NUM_W;

	logic [cfr_pkg::DEN_W-1:0]  max_den_q;
	logic [cfr_pkg::DIV_W-1:0]  q_q;
	logic [cfr_pkg::FRAC_W-1:0] r_q;
	logic [cfr_pkg::NUM_W-1:0]  h1_q, h2_q;
	logic [cfr_pkg::DEN_W-1:0]  k1_q, k2_q;
	logic [cfr_pkg::CNT_W-1:0]  count_q;
	logic [PROD_W-1:0]          eps_prod_q;
	logic [KP_W-1:0]            kprod_q;
	logic [HP_W-1:0]            hprod_q;
	logic [cfr_pkg::DIV_W-1:0]  div_quo;
	logic [cfr_pkg::FRAC_W-1:0] div_rem;
	logic                       div_done;
	logic [ASAT_W-1:0]          a_sat;
	logic [KP_W:0]              k_next;
	logic [HP_W:0]              h_next;
	logic [cfr_pkg::NUM_W-1:0]  h_sat;
	logic                       out_valid_q;
	logic [cfr_pkg::NUM_W-1:0]  num_q;
	logic [cfr_pkg::DEN_W-1:0]  den_q;
	logic                       failed_q;
	logic                       cap_hit;

	cfr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (q_q),
		.divisor   (r_q),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_den_q <= cfr_pkg::MAX_DEN_RESET;
		end else if (cfg_wr) begin
			max_den_q <= cfg_data;
		end
	end

	// Clamp the term: anything beyond the denominator range overshoots anyway
	always_comb begin
		if (div_quo[cfr_pkg::DIV_W-1:cfr_pkg::DEN_W] != '0) begin
			a_sat = {1'b1, {cfr_pkg::DEN_W{1'b0}}};
		end else begin
			a_sat = div_quo[ASAT_W-1:0];
		end
		k_next = {1'b0, kprod_q} + (KP_W+1)'(k2_q);
		h_next = {1'b0, hprod_q} + (HP_W+1)'(h2_q);
		h_sat  = (h_next[HP_W:cfr_pkg::NUM_W] != '0) ? '1 : h_next[cfr_pkg::NUM_W-1:0];
		cap_hit = count_q == cfr_pkg::CNT_W'(cfr_pkg::MAX_TERMS);
	end

	// Expansion state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q     <= {1'b1, {cfr_pkg::FRAC_W{1'b0}}};
			r_q     <= value_fixed[cfr_pkg::FRAC_W-1:0];
			h1_q    <= cfr_pkg::NUM_W'(value_fixed[cfr_pkg::VALUE_W-1:cfr_pkg::FRAC_W]);
			h2_q    <= cfr_pkg::NUM_W'(1);
			k1_q    <= cfr_pkg::DEN_W'(1);
			k2_q    <= '0;
			count_q <= '0;
		end else if (cmd.update) begin
			q_q     <= {1'b0, r_q};
			r_q     <= div_rem;
			h2_q    <= h1_q;
			h1_q    <= h_sat;
			k2_q    <= k1_q;
			k1_q    <= k_next[cfr_pkg::DEN_W-1:0];
			count_q <= count_q + 1'b1;
		end
		if (cmd.eps_mul) begin
			eps_prod_q <= PROD_W'(r_q) * PROD_W'(cfr_pkg::EPS_SCALE);
		end
		if (cmd.mul) begin
			kprod_q <= KP_W'(a_sat) * KP_W'(k1_q);
			hprod_q <= HP_W'(div_quo[cfr_pkg::DEN_W-1:0]) * HP_W'(h1_q);
		end
	end

	// Result register: hold until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			failed_q <= cap_hit;
			num_q    <= cap_hit ? cfr_pkg::NUM_W'(cfr_pkg::FAIL_VALUE) : h1_q;
			den_q    <= cap_hit ? cfr_pkg::DEN_W'(cfr_pkg::FAIL_VALUE) : k1_q;
		end
	end

	always_comb begin
		sts.eps_small  = eps_prod_q < PROD_W'(q_q);
		sts.count_full = cap_hit;
		sts.div_done   = div_done;
		sts.k_over     = k_next > (KP_W+1)'(max_den_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign numerator   = num_q;
	assign denominator = den_q;
	assign failed      = failed_q;

endmodule

// ===== rtl/core/cfr_ctrl.sv =====
// Controller state machine sequencing one expansion term at a time.
// Depends on cfr_pkg.
module cfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cfr_pkg::cfr_sts_t sts,
	output cfr_pkg::cfr_cmd_t cmd
);

	cfr_pkg::cfr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cfr_pkg::S_IDLE:    if (in_valid) state_d = cfr_pkg::S_EPS;
			cfr_pkg::S_EPS:     state_d = cfr_pkg::S_EPS_CHK;
			cfr_pkg::S_EPS_CHK: begin
				if (sts.count_full || sts.eps_small) state_d = cfr_pkg::S_FINISH;
				else state_d = cfr_pkg::S_DIV;
			end
			cfr_pkg::S_DIV:     if (sts.div_done) state_d = cfr_pkg::S_MUL;
			cfr_pkg::S_MUL:     state_d = cfr_pkg::S_UPD;
			cfr_pkg::S_UPD: begin
				if (sts.k_over) state_d = cfr_pkg::S_FINISH;
				else state_d = cfr_pkg::S_EPS;
			end
			cfr_pkg::S_FINISH:  if (sts.out_free) state_d = cfr_pkg::S_IDLE;
			default:            state_d = cfr_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			cfr_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			cfr_pkg::S_EPS:     cmd.eps_mul = 1'b1;
			cfr_pkg::S_EPS_CHK: cmd.div_start = !(sts.count_full || sts.eps_small);
			cfr_pkg::S_MUL:     cmd.mul = 1'b1;
			cfr_pkg::S_UPD:     cmd.update = !sts.k_over;
			cfr_pkg::S_FINISH:  cmd.out_load = sts.out_free;
			default:            cmd = '0;
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd)) else $error("more than one datapath command");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfr_pkg::S_DIV && !sts.div_done) |=> state_q == cfr_pkg::S_DIV)
		else $error("left divide before done");
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == cfr_pkg::S_IDLE) else $error("no return to idle");

endmodule

// ===== rtl/core/continued_fraction_ratio_unit.sv =====
// Top level of the continued fraction ratio unit.
// Depends on cfr_pkg, cfr_ctrl and cfr_dpath.
//
// Usage:
//  Input channel in_valid/in_stall carries value_fixed (unsigned Q16.32).
//  Output channel out_valid/out_stall returns numerator, denominator and
//  failed, exactly one transaction per input transaction.
//  cfg_valid/cfg_ready writes max_denominator; cfg_ready is always high and
//  writes are expected only while the unit is idle.
//  One input is processed at a time. The time per term is dominated by the
//  one-bit-per-cycle 33-bit divider; the expansion ends on the epsilon check,
//  the term cap or the denominator limit, and the result register then holds
//  the ratio. An expansion has at most 100 terms.
//  Reset clears the controller, the result valid flag, and sets
//  max_denominator to 1000.
//  When out_stall is high the result is held; a new input is still taken
//  and expanded, but its result waits until the register is free.
module continued_fraction_ratio_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cfr_pkg::VALUE_W-1:0] value_fixed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cfr_pkg::NUM_W-1:0]   numerator,
	output logic [cfr_pkg::DEN_W-1:0]   denominator,
	output logic                        failed,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cfr_pkg::DEN_W-1:0]   cfg_data
);

	cfr_pkg::cfr_cmd_t cmd;
	cfr_pkg::cfr_sts_t sts;

	assign cfg_ready = 1'b1;

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value_fixed (value_fixed),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.numerator   (numerator),
		.denominator (denominator),
		.failed      (failed)
	);

endmodule

// ===== tb/continued_fraction_ratio_unit_tb.sv =====
// Self-checking testbench for continued_fraction_ratio_unit.
// Depends on cfr_pkg and the unit's RTL; an internal convergent predictor
// supplies expected results, compared against every output transaction.
module continued_fraction_ratio_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [cfr_pkg::NUM_W-1:0] num;
		logic [cfr_pkg::DEN_W-1:0] den;
		logic                      fail;
	} ratio_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [cfr_pkg::VALUE_W-1:0]  value_fixed;
	logic                         out_valid;
	logic                         out_stall;
	logic [cfr_pkg::NUM_W-1:0]    numerator;
	logic [cfr_pkg::DEN_W-1:0]    denominator;
	logic                         failed;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [cfr_pkg::DEN_W-1:0]    cfg_data;

	ratio_t                     ratio_q[$];
	logic [cfr_pkg::DEN_W-1:0]  max_den;
	int                         mismatches;
	int                         results_seen;
	int                         fail_results;
	bit                         stall_quiet;

	continued_fraction_ratio_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .value_fixed(value_fixed),
		.out_valid(out_valid), .out_stall(out_stall),
		.numerator(numerator), .denominator(denominator), .failed(failed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Expand the value by exact Euclidean steps and keep the best convergent
	function automatic ratio_t best_convergent(logic [cfr_pkg::VALUE_W-1:0] v);
		logic [63:0] p, q, a, r, h, k, h1, h2, k1, k2, num, den;
		int          terms;
		ratio_t      res;
		p = 64'(v);
		q = 64'd1 << cfr_pkg::FRAC_W;
		a = p / q;
		r = p % q;
		h1 = a; h2 = 64'd1; k1 = 64'd1; k2 = 64'd0;
		num = a; den = 64'd1;
		terms = 0;
		while (terms < cfr_pkg::MAX_TERMS) begin
			if (r * 64'(cfr_pkg::EPS_SCALE) < q)
				break;
			p = q;
			q = r;
			a = p / q;
			r = p % q;
			h = a * h1 + h2;
			k = a * k1 + k2;
			if (k > 64'(max_den))
				break;
			h2 = h1; h1 = h;
			k2 = k1; k1 = k;
			num = h; den = k;
			terms++;
		end
		if (terms == cfr_pkg::MAX_TERMS) begin
			res.num = cfr_pkg::NUM_W'(cfr_pkg::FAIL_VALUE);
			res.den = cfr_pkg::DEN_W'(cfr_pkg::FAIL_VALUE);
			res.fail = 1'b1;
		end else begin
			res.num = (num > 64'hFFFF_FFFF) ? '1 : num[cfr_pkg::NUM_W-1:0];
			res.den = den[cfr_pkg::DEN_W-1:0];
			res.fail = 1'b0;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Draw a gap length: mostly none or short, occasionally long
	function automatic int gap_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50) return 0;
		if (sel < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// Send one value and queue its predicted ratio on acceptance
	task automatic send_value(logic [cfr_pkg::VALUE_W-1:0] v);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			idle_cycles(n);
		end
		in_valid <= 1'b1;
		value_fixed <= v;
		do @(posedge clk); while (in_stall);
		ratio_q.push_back(best_convergent(v));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (ratio_q.size() != 0 && guard < 2000000) begin
			@(posedge clk);
			guard++;
		end
		idle_cycles(8);
	endtask

	// Write the denominator limit while the unit is idle
	task automatic write_limit(logic [cfr_pkg::DEN_W-1:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_den = d;
	endtask

	// Stall the result channel at random
	always @(posedge clk) begin
		if (stall_quiet)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < 30);
	end

	// Compare every output transaction against the oldest prediction
	always @(posedge clk) begin
		ratio_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (ratio_q.size() == 0) begin
				report_mismatch("result with no expectation");
			end else begin
				exp_r = ratio_q.pop_front();
				if (exp_r.fail) fail_results++;
				if (numerator !== exp_r.num)
					report_mismatch($sformatf("numerator %0d expected %0d",
						numerator, exp_r.num));
				if (denominator !== exp_r.den)
					report_mismatch($sformatf("denominator %0d expected %0d",
						denominator, exp_r.den));
				if (failed !== exp_r.fail)
					report_mismatch($sformatf("failed %0b expected %0b",
						failed, exp_r.fail));
			end
		end
	end

	task automatic test_field_extremes();
		send_value('0);
		send_value('1);
		send_value(48'h1_0000_0000);
		send_value(48'hFFFF_0000_0000);
		send_value(48'h0000_FFFF_FFFF);
		send_value(48'h0000_0000_0001);
		send_value(48'hAAAA_5555_AAAA);
		send_value(48'h5555_AAAA_5555);
		send_value(48'h0003_243F_6A88);
		send_value(48'h0000_8000_0000);
		send_value(48'h0000_0000_1000);
	endtask

	// Golden ratio has all terms 1, the slowest growth of denominators
	task automatic test_iteration_cap();
		write_limit(16'hFFFF);
		send_value(48'h0001_9E37_79B9);
		send_value(48'h0000_9E37_79B9);
		send_value(48'h0002_B7E1_5162);
		write_limit(16'd1);
		send_value(48'h0001_9E37_79B9);
		send_value(48'h0000_FFFF_FFFF);
		write_limit(16'd0);
		send_value(48'h0003_243F_6A88);
		send_value(48'h0000_0000_0001);
	endtask

	task automatic test_random_values();
		logic [15:0] limits[5];
		logic [cfr_pkg::VALUE_W-1:0] v;
		int sel;
		limits = '{16'd1000, 16'd7, 16'd65535, 16'd113, 16'd2};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			stall_quiet = (i == 3);
			repeat (230) begin
				sel = $urandom_range(0, 9);
				v = cfr_pkg::VALUE_W'({$urandom, $urandom});
				if (sel < 3) v[47:32] = 16'($urandom_range(0, 3));
				else if (sel == 3) v[31:0] = '0;
				else if (sel == 4) v[31:0] = 32'($urandom_range(0, 5000));
				send_value(v);
			end
			stall_quiet = 1'b0;
		end
		write_limit(16'($urandom_range(1, 65535)));
		repeat (20) send_value(cfr_pkg::VALUE_W'({$urandom, $urandom}));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_fixed = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		max_den = cfr_pkg::MAX_DEN_RESET;
		mismatches = 0;
		results_seen = 0;
		fail_results = 0;
		stall_quiet = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_iteration_cap();
		test_random_values();
		drain();
		idle_cycles(50);
		$display("checked %0d ratios, %0d at the term cap, limits 0 to 65535",
			results_seen, fail_results);
		if (mismatches == 0 && ratio_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// End the run if it hangs
	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

endmodule
